// ===== rtl/edd_pkg.sv =====
`default_nettype none

package edd_pkg;

  // Fixed field widths
  localparam int PIX_W      = 8;
  localparam int ERR_W      = 11;
  localparam int CFG_W      = 12;
  localparam int MATH_W     = 16;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Register indexes (paddr[2])
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

  // Output pixel levels
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

  // Output queue
  localparam int Q_DEPTH = 3;

  typedef logic signed [ERR_W-1:0]  err_t;
  typedef logic signed [MATH_W-1:0] math_t;

  // Signed divide by 16, truncating toward zero
  function automatic math_t div16(input math_t p);
    math_t biased;
    biased = p + ((p < 0) ? math_t'(15) : math_t'(0));
    return biased >>> 4;
  endfunction

  // Saturate to the signed 11-bit range
  function automatic err_t sat11(input math_t v);
    err_t r;
    if (v > math_t'(1023)) begin
      r = err_t'(1023);
    end else if (v < math_t'(-1024)) begin
      r = err_t'(-1024);
    end else begin
      r = err_t'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/error_diffusion_dither.sv =====
// Floyd-Steinberg error diffusion dither for 8-bit grayscale pixels.
// in_*  : source pixels in raster order, one per item (in_tdata).
// out_* : dithered pixel (0 or 255) on out_tdata, out_tlast high on the
//         last pixel of the frame. One result per input item, same order.
// cfg_* : APB-style registers: 0x0 image_width, 0x4 image_height (12 bits).
//         Write only while the stream is idle.
// An accepted item passes the stage 1 registers, then the output queue.
// Throughput is one item per clock while in_tready is high: each item does
// one line-store read when accepted and its read-modify-write in the next
// cycle, and the error carried to the right neighbor closes within that cycle.
// The line store is split into even and odd column banks so that the two
// writes of a row's last pixel land in the same cycle; a write that hits the
// entry being read in the same cycle is forwarded.
// Reset: counters and carried errors clear at once; then a clearing pass
// zeroes each bank's (MAX_WIDTH+1)/2 entries, in_tready low throughout.
// Stall: a three-entry output queue absorbs the result in flight, so after
// clearing, in_tready drops only when the queue has no room; none is lost.
`default_nettype none

module error_diffusion_dither #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: [7:0] pixel_in
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [edd_pkg::PIX_W-1:0]           in_tdata,
  // out_tdata: [7:0] pixel_out
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [edd_pkg::PIX_W-1:0]           out_tdata,
  output logic                                     out_tlast,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [edd_pkg::APB_ADDR_W-1:0]      cfg_paddr,
  input  wire logic [edd_pkg::APB_DATA_W-1:0]      cfg_pwdata,
  output logic      [edd_pkg::APB_DATA_W-1:0]      cfg_prdata,
  output logic                                     cfg_pready
);

  import edd_pkg::*;

  localparam int AW         = $clog2(MAX_WIDTH);
  localparam int BANK_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int CMPW       = (AW > CFG_W) ? AW : CFG_W;

  localparam logic [CMPW-1:0] MAXW_M1   = CMPW'(MAX_WIDTH - 1);
  localparam logic [BAW-1:0]  CLR_LAST  = BAW'(BANK_DEPTH - 1);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_WIDTH:  width_r  <= cfg_pwdata[CFG_W-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[CFG_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_WIDTH:  cfg_prdata = APB_DATA_W'(width_r);
      REG_HEIGHT: cfg_prdata = APB_DATA_W'(height_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Clearing pass over the line store after reset
  // ---------------------------------------------------------------
  logic           clr_busy_r;
  logic [BAW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == CLR_LAST) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // Accept stage: position counters, line-store read
  // ---------------------------------------------------------------
  logic [AW-1:0]    col_r, col_nxt;
  logic [CFG_W-1:0] row_r, row_nxt;
  logic [CFG_W-1:0] w_m1, h_m1;
  logic             last_col, last_row;
  logic             accept;
  logic [BAW-1:0]   rd_baddr;

  assign accept = in_tvalid && in_tready;
  assign w_m1   = (width_r == '0)  ? '0 : width_r - 1'b1;
  assign h_m1   = (height_r == '0) ? '0 : height_r - 1'b1;

  assign last_col = (CMPW'(col_r) >= CMPW'(w_m1)) || (CMPW'(col_r) >= MAXW_M1);
  assign last_row = (row_r >= h_m1);

  always_comb begin
    col_nxt = col_r + 1'b1;
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign rd_baddr = BAW'(col_r >> 1);

  // ---------------------------------------------------------------
  // Line store: even and odd column banks
  // ---------------------------------------------------------------
  logic             bank_we    [2];
  logic [BAW-1:0]   bank_waddr [2];
  logic [ERR_W-1:0] bank_wdata [2];
  logic [ERR_W-1:0] bank_rdata [2];

  for (genvar g = 0; g < 2; g++) begin : g_bank
    edd_ram #(
      .WIDTH (ERR_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we[g]),
      .waddr (bank_waddr[g]),
      .wdata (bank_wdata[g]),
      .raddr (rd_baddr),
      .rdata (bank_rdata[g])
    );
  end

  // ---------------------------------------------------------------
  // Stage 1 registers
  // ---------------------------------------------------------------
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [AW-1:0]    s1_x_r;
  logic             s1_last_col_r;
  logic             s1_last_row_r;
  logic             s1_y_nz_r;
  logic             s1_fwd_hit_r;
  err_t             s1_fwd_data_r;
  logic             fwd_hit;

  // Same-cycle write to the entry being read: take the write data
  assign fwd_hit = bank_we[col_r[0]] && (bank_waddr[col_r[0]] == rd_baddr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r      <= in_tdata;
      s1_x_r        <= col_r;
      s1_last_col_r <= last_col;
      s1_last_row_r <= last_row;
      s1_y_nz_r     <= (row_r != '0);
      s1_fwd_hit_r  <= fwd_hit;
      s1_fwd_data_r <= err_t'(bank_wdata[col_r[0]]);
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: threshold, error shares, line-store write back
  // ---------------------------------------------------------------
  err_t          right_err_r;
  err_t          acc_left_r;
  err_t          acc_here_r;
  err_t          rd_val;
  math_t         owed, val, err;
  math_t         sh7, sh3, sh5, sh1;
  logic          pix_hi;
  err_t          wr_a_data, acc_left_new, acc_here_new;
  logic          wr_a_en, wr_b_en;
  logic [AW-1:0] xm1;

  assign rd_val = s1_fwd_hit_r ? s1_fwd_data_r : err_t'(bank_rdata[s1_x_r[0]]);
  assign owed   = math_t'(right_err_r) + (s1_y_nz_r ? math_t'(rd_val) : math_t'(0));
  assign val    = $signed(MATH_W'(s1_pix_r)) + owed;
  assign pix_hi = (val > math_t'(128));
  assign err    = val - (pix_hi ? math_t'(255) : math_t'(0));

  assign sh7 = div16(err * math_t'(7));
  assign sh3 = div16(err * math_t'(3));
  assign sh5 = div16(err * math_t'(5));
  assign sh1 = div16(err);

  assign wr_a_data    = sat11(math_t'(acc_left_r) + sh3);
  assign acc_left_new = sat11(math_t'(acc_here_r) + sh5);
  assign acc_here_new = s1_last_col_r ? err_t'(0) : sat11(sh1);

  assign xm1     = s1_x_r - 1'b1;
  assign wr_a_en = s1_valid_r && !s1_last_row_r && (s1_x_r != '0);
  assign wr_b_en = s1_valid_r && !s1_last_row_r && s1_last_col_r;

  // Column x-1 and column x fall in different banks
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      bank_we[k]    = 1'b0;
      bank_waddr[k] = '0;
      bank_wdata[k] = '0;
      if (clr_busy_r) begin
        bank_we[k]    = 1'b1;
        bank_waddr[k] = clr_addr_r;
      end else if (wr_a_en && (xm1[0] == k[0])) begin
        bank_we[k]    = 1'b1;
        bank_waddr[k] = BAW'(xm1 >> 1);
        bank_wdata[k] = wr_a_data;
      end else if (wr_b_en && (s1_x_r[0] == k[0])) begin
        bank_we[k]    = 1'b1;
        bank_waddr[k] = BAW'(s1_x_r >> 1);
        bank_wdata[k] = acc_left_new;
      end
    end
  end

  // Carried errors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_err_r <= '0;
      acc_left_r  <= '0;
      acc_here_r  <= '0;
    end else if (s1_valid_r) begin
      if (s1_last_col_r) begin
        right_err_r <= '0;
        acc_left_r  <= '0;
        acc_here_r  <= '0;
      end else begin
        right_err_r <= sat11(sh7);
        if (!s1_last_row_r) begin
          acc_left_r <= acc_left_new;
          acc_here_r <= acc_here_new;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Output queue
  // ---------------------------------------------------------------
  logic [PIX_W:0] q_mem [Q_DEPTH];
  logic [1:0]     q_wr_r, q_rd_r, q_cnt_r;
  logic           q_push, q_pop;
  logic [2:0]     in_flight;

  assign q_push = s1_valid_r;
  assign q_pop  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (q_push) begin
        q_wr_r <= (q_wr_r == 2'(Q_DEPTH - 1)) ? '0 : q_wr_r + 1'b1;
      end
      if (q_pop) begin
        q_rd_r <= (q_rd_r == 2'(Q_DEPTH - 1)) ? '0 : q_rd_r + 1'b1;
      end
      q_cnt_r <= q_cnt_r + 2'(q_push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_wr_r] <= {s1_last_col_r && s1_last_row_r, pix_hi ? PIX_WHITE : PIX_BLACK};
    end
  end

  assign out_tvalid = (q_cnt_r != '0);
  assign out_tdata  = q_mem[q_rd_r][PIX_W-1:0];
  assign out_tlast  = q_mem[q_rd_r][PIX_W];

  // Room for the queued items, the one in stage 1 and a new one
  assign in_flight = 3'(q_cnt_r) + 3'(s1_valid_r);
  assign in_tready = !clr_busy_r && (in_flight < 3'(Q_DEPTH));

endmodule

`default_nettype wire

// ===== rtl/edd_ram.sv =====
`default_nettype none

module edd_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single write port, registered read (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/edd_checker.sv =====
`default_nettype none

module edd_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_tvalid,
  input wire logic                      in_tready,
  input wire logic                      out_tvalid,
  input wire logic                      out_tready,
  input wire logic [edd_pkg::PIX_W-1:0] out_tdata,
  input wire logic                      out_tlast
);

  import edd_pkg::*;

  // Reset empties the result side
  a_reset_no_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high right after reset");

  // Line store clearing keeps the input closed after reset
  a_reset_no_in: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("in_tready high right after reset");

  // A dithered pixel is full black or full white
  a_two_level: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid |-> (out_tdata == PIX_BLACK || out_tdata == PIX_WHITE))
    else $error("output pixel is neither black nor white");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled item changed");

endmodule

bind error_diffusion_dither edd_checker u_edd_checker (.*);

`default_nettype wire

// ===== dv/edd_checker.sv =====
`timescale 1ns / 100ps

// Watches the pixel, result and register ports of the dither block, keeps its
// own copy of the diffusion state, and compares every dithered pixel in order.
module edd_scoreboard #(
  parameter int LINE_MAX = 2048
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [edd_pkg::PIX_W-1:0]      in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [edd_pkg::PIX_W-1:0]      out_tdata,
  input  logic                           out_tlast,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [edd_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  logic [edd_pkg::APB_DATA_W-1:0] cfg_pwdata,
  input  logic [edd_pkg::APB_DATA_W-1:0] cfg_prdata,
  input  logic                           cfg_pready,
  input  logic                           drain_done,
  output int                             pending,
  output int                             error_count
);

  import edd_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] level;
    logic             frame_end;
  } dithered_t;

  // Shadow registers and diffusion state
  logic [CFG_W-1:0] shadow_width;
  logic [CFG_W-1:0] shadow_height;
  int line_err [LINE_MAX];
  int carry_right;
  int acc_prev;   // owed to column x-1 of the next row
  int acc_cur;    // owed to column x of the next row
  int col_cnt;
  int row_cnt;

  dithered_t expected_pixels[$];
  bit        leftovers_checked;

  initial begin
    pending = 0;
    error_count = 0;
    leftovers_checked = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    error_count++;
  endtask

  function automatic int clip11(input int v);
    if (v > 1023) return 1023;
    if (v < -1024) return -1024;
    return v;
  endfunction

  task automatic clear_state();
    shadow_width = WIDTH_RESET;
    shadow_height = HEIGHT_RESET;
    foreach (line_err[i]) line_err[i] = 0;
    carry_right = 0;
    acc_prev = 0;
    acc_cur = 0;
    col_cnt = 0;
    row_cnt = 0;
    expected_pixels.delete();
  endtask

  // Dither one source pixel and queue the expected result
  task automatic dither_pixel(input logic [PIX_W-1:0] pix);
    int w, h, x, y;
    int owed, val, err, s7, s3, s5, s1;
    bit col_end, row_end;
    dithered_t r;
    w = (shadow_width == '0) ? 1 : int'(shadow_width);
    if (w > LINE_MAX) w = LINE_MAX;
    h = (shadow_height == '0) ? 1 : int'(shadow_height);
    x = (col_cnt >= LINE_MAX) ? LINE_MAX - 1 : col_cnt;
    y = row_cnt;
    col_end = (x + 1 >= w);
    row_end = (y + 1 >= h);

    owed = carry_right;
    if (y > 0) owed += line_err[x];
    val = int'(pix) + owed;
    r.level = (val > 128) ? PIX_WHITE : PIX_BLACK;
    err = val - int'(r.level);

    // signed int division truncates toward zero
    s7 = (err * 7) / 16;
    s3 = (err * 3) / 16;
    s5 = (err * 5) / 16;
    s1 = err / 16;

    carry_right = col_end ? 0 : clip11(s7);
    // the last row owes nothing to a next row
    if (!row_end) begin
      if (x > 0) line_err[x-1] = clip11(acc_prev + s3);
      acc_prev = clip11(acc_cur + s5);
      acc_cur = col_end ? 0 : clip11(s1);
      if (col_end) line_err[x] = acc_prev;
    end

    r.frame_end = col_end && row_end;
    expected_pixels.push_back(r);

    if (col_end) begin
      col_cnt = 0;
      carry_right = 0;
      acc_prev = 0;
      acc_cur = 0;
      row_cnt = row_end ? 0 : y + 1;
    end else begin
      col_cnt = x + 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
    end else begin
      // register port: track writes, check reads
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr[2] == REG_WIDTH) shadow_width = cfg_pwdata[CFG_W-1:0];
          else shadow_height = cfg_pwdata[CFG_W-1:0];
        end else begin
          logic [APB_DATA_W-1:0] want;
          want = (cfg_paddr[2] == REG_WIDTH) ? APB_DATA_W'(shadow_width)
                                              : APB_DATA_W'(shadow_height);
          if (cfg_prdata !== want)
            report_mismatch($sformatf("register read at %0d: got %0d, want %0d",
                                      cfg_paddr, cfg_prdata, want));
        end
      end

      // result channel
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected result item %0d/%0b", out_tdata, out_tlast));
        end else begin
          dithered_t e;
          e = expected_pixels.pop_front();
          if (out_tdata !== e.level)
            report_mismatch($sformatf("pixel_out got %0d, want %0d", out_tdata, e.level));
          if (out_tlast !== e.frame_end)
            report_mismatch($sformatf("frame_end got %0b, want %0b", out_tlast, e.frame_end));
        end
      end

      // source pixel channel
      if (in_tvalid && in_tready) dither_pixel(in_tdata);

      if (drain_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_pixels.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
      end
    end
    pending = expected_pixels.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import edd_pkg::*;

  localparam int LINE_MAX = 2048;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata;     // [7:0] pixel_in
  logic                  out_tvalid;
  logic                  out_tready;
  logic [PIX_W-1:0]      out_tdata;    // [7:0] pixel_out
  logic                  out_tlast;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [APB_ADDR_W-1:0] cfg_paddr;
  logic [APB_DATA_W-1:0] cfg_pwdata;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  logic                  drain_done;
  int                    pending;
  int                    error_count;

  // idle behavior of each side, changed per phase
  bit source_calm;
  bit sink_calm;
  int ramp_level;
  int random_sent;
  bit paused_once;

  error_diffusion_dither #(.MAX_WIDTH(LINE_MAX)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  edd_scoreboard #(.LINE_MAX(LINE_MAX)) u_scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .drain_done(drain_done), .pending(pending), .error_count(error_count)
  );

  always #1 clk = ~clk;

  // Run limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int draw_gap(input bit calm);
    if (calm) return 0;
    case ($urandom_range(0, 2))
      0: return 0;
      1: return $urandom_range(0, 3);
      default: return $urandom_range(0, 17);
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(input int style);
    case (style)
      0: return PIX_W'($urandom_range(0, 255));
      1: return $urandom_range(0, 1) ? PIX_WHITE : PIX_BLACK;
      2: return PIX_W'($urandom_range(124, 132));
      default: begin
        ramp_level = (ramp_level + $urandom_range(0, 5)) % 256;
        return PIX_W'(ramp_level);
      end
    endcase
  endfunction

  // Register access, setup then access cycle; called at a falling edge
  task automatic cfg_access(input logic wr, input logic sel, input logic [CFG_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= APB_DATA_W'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    cfg_access(1'b1, REG_WIDTH, w);
    cfg_access(1'b0, REG_WIDTH, '0);
    cfg_access(1'b1, REG_HEIGHT, h);
    cfg_access(1'b0, REG_HEIGHT, '0);
  endtask

  // Offer one pixel after a random gap; returns at the falling edge after accept
  task automatic push_pixel(input logic [PIX_W-1:0] pix);
    int gap;
    gap = draw_gap(source_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop the source and let every queued result come out
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic pick_idling();
    source_calm = ($urandom_range(0, 3) == 0);
    sink_calm   = ($urandom_range(0, 3) == 0);
  endtask

  // Result side: random stalls per item
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      int gap;
      gap = draw_gap(sink_calm);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    logic [PIX_W-1:0] corner_pixels [9];
    int w_eff, h_eff, frame_px, total, style;
    logic [CFG_W-1:0] w_reg, h_reg;

    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    drain_done = 1'b0;
    source_calm = 1'b0;
    sink_calm = 1'b0;
    ramp_level = 0;
    random_sent = 0;
    paused_once = 1'b0;
    corner_pixels = '{8'd0, 8'd255, 8'd128, 8'd129, 8'd127, 8'd1, 8'd254, 8'd64, 8'd192};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values read back
    cfg_access(1'b0, REG_WIDTH, '0);
    cfg_access(1'b0, REG_HEIGHT, '0);

    // zero width and height act as a 1x1 frame
    set_geometry(12'd0, 12'd0);
    push_pixel(8'd255);
    push_pixel(8'd0);
    drain();

    // threshold edges and extremes on a 3x3 frame
    set_geometry(12'd3, 12'd3);
    foreach (corner_pixels[i]) push_pixel(corner_pixels[i]);
    drain();

    // shrink the frame mid-row: counters past the new last index wrap
    set_geometry(12'd5, 12'd4);
    for (int i = 0; i < 7; i++) push_pixel(pick_pixel(0));
    drain();
    set_geometry(12'd2, 12'd1);
    for (int i = 0; i < 6; i++) push_pixel(pick_pixel(1));
    drain();

    // widest line: width register all ones clamps to the line store size
    pick_idling();
    set_geometry(12'hFFF, 12'd2);
    for (int i = 0; i < LINE_MAX + 8; i++) push_pixel(pick_pixel(i % 4));
    drain();

    // random geometries, mostly whole frames with random content
    while (random_sent < 200) begin
      pick_idling();
      case ($urandom_range(0, 9))
        0: w_reg = 12'd0;
        1: w_reg = 12'd1;
        2: w_reg = CFG_W'($urandom_range(17, 64));
        default: w_reg = CFG_W'($urandom_range(2, 16));
      endcase
      case ($urandom_range(0, 9))
        0: h_reg = 12'd0;
        1: h_reg = 12'd1;
        2: h_reg = $urandom_range(0, 1) ? 12'hFFF : CFG_W'($urandom_range(100, 2048));
        default: h_reg = CFG_W'($urandom_range(2, 6));
      endcase
      w_eff = (w_reg == '0) ? 1 : int'(w_reg);
      h_eff = (h_reg == '0) ? 1 : int'(h_reg);
      frame_px = w_eff * h_eff;
      if (frame_px <= 100) begin
        total = frame_px * $urandom_range(1, 2);
        if ($urandom_range(0, 3) == 0) total += $urandom_range(1, w_eff);
      end else begin
        total = $urandom_range(20, 80);
      end
      style = $urandom_range(0, 4);

      set_geometry(w_reg, h_reg);
      for (int i = 0; i < total; i++) begin
        if (!paused_once && i == total / 2) begin
          // hold the source until every result is out, then resume mid-frame
          paused_once = 1'b1;
          in_tvalid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
        push_pixel(pick_pixel(style == 4 ? $urandom_range(0, 3) : style));
      end
      random_sent += total;
      drain();
    end

    repeat (8) @(negedge clk);
    drain_done <= 1'b1;
    repeat (2) @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
